// ----- rtl/mtg_pkg.sv -----
// ============================================================================
// mtg_pkg - shared types, constants and functions of the twister generator
// state encoding, MT19937 constants, the seeding generator and tempering
// ============================================================================
package mtg_pkg;

    // store geometry
    localparam int unsigned MT_STATE_WORDS  = 624;
    localparam int unsigned MT_TWIST_OFFSET = 397;

    // twist and tempering constants
    localparam logic [31:0] MT_MATRIX    = 32'h9908_b0df;
    localparam logic [31:0] MT_TEMPER_B  = 32'h9d2c_5680;
    localparam logic [31:0] MT_TEMPER_C  = 32'hefc6_0000;

    // seeding linear congruential generator
    localparam logic [31:0] MT_LCG_MUL   = 32'd69069;
    localparam logic [31:0] MT_LCG_INC   = 32'd1;

    // request opcodes
    localparam logic OP_RESEED = 1'b0;
    localparam logic OP_DRAW   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_RD_NEAR,
        ST_RD_FAR,
        ST_TWIST
    } t_state;

    // one twist step: y holds the top bit of the current word and the
    // low 31 bits of the following one
    function automatic logic [31:0] mt_twist(input logic [31:0] y,
                                             input logic [31:0] far);
        logic [31:0] r;
        r = far ^ (y >> 1);
        if (y[0]) begin
            r = r ^ MT_MATRIX;
        end
        return r;
    endfunction

    function automatic logic [31:0] mt_temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ----- rtl/mersenne_twister_generator_core.sv -----
// ============================================================================
// mersenne_twister_generator_core - 32-bit MT19937 word generator
// seeds a 624-word state store and delivers one tempered word per draw
// ============================================================================
//
// input channel: i_in_valid / o_in_stall carry one request, i_op selects
// reseed (i_seed_value used) or draw. output channel: o_out_valid /
// i_out_stall carry o_random_word, one per draw, none per reseed.
//
// a reseed runs the seeding generator through one 32x32 multiplier, one
// multiply a cycle and two per store word, so it occupies the block until
// the last store word is written. the twist is done lazily: each draw reads
// the current, next and far words (two read ports), twists the one word,
// writes it back and tempers it on the way out. a draw steps through the
// near read, the far read and the twist; the result is registered as the
// twist completes, while the twisted word is written back.
//
// o_in_stall is high whenever a request is in progress. a finished result
// sits in the output register; while the receiver stalls a further request
// is still taken, and a later draw waits in its last step until the
// register frees. reset clears the sequencer and the output valid only: the
// store is undefined until the first reseed, which must come first.
//
module mersenne_twister_generator_core #(
    parameter int unsigned STATE_WORDS  = mtg_pkg::MT_STATE_WORDS,
    parameter int unsigned TWIST_OFFSET = mtg_pkg::MT_TWIST_OFFSET
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [0:0]  i_op,
    input  logic [31:0] i_seed_value,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_random_word
);
    import mtg_pkg::*;

    localparam int unsigned AW = $clog2(STATE_WORDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STATE_WORDS - 1);
    localparam logic [AW:0]   FAR_OFF   = (AW+1)'(TWIST_OFFSET);
    localparam logic [AW:0]   WORDS_X   = (AW+1)'(STATE_WORDS);

    // sequencer and control
    t_state        r_state, n_state;
    logic [AW-1:0] r_ptr, n_ptr;        // next word to draw
    logic [AW-1:0] r_cnt, n_cnt;        // seeding fill address
    logic          r_half, n_half;      // second multiply of a seed word
    logic          r_out_valid, n_out_valid;

    // payload
    logic [31:0]   r_lcg, n_lcg;
    logic [15:0]   r_hi, n_hi;
    logic [31:0]   r_y, n_y;
    logic [31:0]   r_out_word, n_out_word;

    // state store, one write and two read ports, registered reads
    logic [31:0]   r_mem [STATE_WORDS];
    logic [31:0]   r_rd0, r_rd1;
    logic [AW-1:0] rd_addr0, rd_addr1, wr_addr;
    logic          wr_en;
    logic [31:0]   wr_data;

    // address arithmetic
    logic [AW-1:0] ptr_next;
    logic [AW:0]   far_sum;
    logic [AW-1:0] far_addr;

    // seeding multiplier, twist result and handshake terms
    logic [31:0]   lcg_step;
    logic [31:0]   twisted;
    logic          in_take;
    logic          out_take;

    assign ptr_next = (r_ptr == LAST_ADDR) ? '0 : r_ptr + AW'(1);
    assign far_sum  = {1'b0, r_ptr} + FAR_OFF;
    assign far_addr = (far_sum >= WORDS_X) ? AW'(far_sum - WORDS_X) : far_sum[AW-1:0];

    assign lcg_step = r_lcg * MT_LCG_MUL + MT_LCG_INC;
    assign twisted  = mt_twist(r_y, r_rd0);

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_random_word = r_out_word;

    assign in_take  = i_in_valid && (r_state == ST_IDLE);
    assign out_take = r_out_valid && !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_half      = r_half;
        n_out_valid = r_out_valid;
        n_lcg       = r_lcg;
        n_hi        = r_hi;
        n_y         = r_y;
        n_out_word  = r_out_word;
        rd_addr0    = r_ptr;
        rd_addr1    = ptr_next;
        wr_en       = 1'b0;
        wr_addr     = r_cnt;
        wr_data     = {r_hi, lcg_step[31:16]};

        if (out_take) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    if (i_op == OP_RESEED) begin
                        n_lcg   = i_seed_value;
                        n_cnt   = '0;
                        n_half  = 1'b0;
                        n_state = ST_SEED;
                    end else begin
                        n_state = ST_RD_NEAR;
                    end
                end
            end
            ST_SEED: begin
                // one multiply a cycle; upper halves of two steps form a word
                n_lcg = lcg_step;
                if (!r_half) begin
                    n_hi   = lcg_step[31:16];
                    n_half = 1'b1;
                end else begin
                    wr_en  = 1'b1;
                    n_half = 1'b0;
                    if (r_cnt == LAST_ADDR) begin
                        n_ptr   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + AW'(1);
                    end
                end
            end
            ST_RD_NEAR: begin
                // current and following word on the way
                n_state = ST_RD_FAR;
            end
            ST_RD_FAR: begin
                rd_addr0 = far_addr;
                n_y      = {r_rd0[31], r_rd1[30:0]};
                n_state  = ST_TWIST;
            end
            ST_TWIST: begin
                // keep the far word addressed while the output is held
                rd_addr0 = far_addr;
                if (!r_out_valid || out_take) begin
                    wr_en       = 1'b1;
                    wr_addr     = r_ptr;
                    wr_data     = twisted;
                    n_out_word  = mt_temper(twisted);
                    n_out_valid = 1'b1;
                    n_ptr       = ptr_next;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_cnt       <= n_cnt;
            r_half      <= n_half;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lcg      <= n_lcg;
        r_hi       <= n_hi;
        r_y        <= n_y;
        r_out_word <= n_out_word;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd0 <= r_mem[rd_addr0];
        r_rd1 <= r_mem[rd_addr1];
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top - self-checking bench for the MT19937 word generator core
// predicts every tempered word from its own model of the 624-word store and
// compares it with the core's output under random pacing and back-pressure
// ============================================================================
module tb_top;

    import mtg_pkg::*;

    // generator geometry and constants, kept independent of the design
    localparam int unsigned STORE_DEPTH   = 624;
    localparam int unsigned FAR_DISTANCE  = 397;
    localparam logic [31:0] SEED_MUL      = 32'd69069;
    localparam logic [31:0] SEED_ADD      = 32'd1;
    localparam logic [31:0] TWIST_XOR     = 32'h9908_b0df;
    localparam logic [31:0] TOP_BIT_SEL   = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS_SEL  = 32'h7fff_ffff;
    localparam logic [31:0] TEMPER_MASK_B = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_MASK_C = 32'hefc6_0000;

    localparam int unsigned LONG_HOLD_CYCLES = 200;
    localparam int unsigned WATCHDOG_LIMIT   = 8000;
    localparam int unsigned SETTLE_CYCLES    = 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [0:0]  i_op;
    logic [31:0] i_seed_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_random_word;

    mersenne_twister_generator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_seed_value  (i_seed_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_random_word (o_random_word)
    );

    // predicted generator state
    logic [31:0] mt_store [0:STORE_DEPTH-1];
    int unsigned mt_index;

    logic [31:0] expected_words [$];

    int unsigned error_count;
    int unsigned reseeds_sent;
    int unsigned draws_sent;
    int unsigned words_checked;
    int unsigned wraps_seen;
    int unsigned burst_left;
    int unsigned hold_requests;
    int unsigned holds_done;
    int unsigned idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic void regenerate_store();
        logic [31:0] y;
        logic [31:0] r;
        for (int k = 0; k < STORE_DEPTH; k++) begin
            y = (mt_store[k] & TOP_BIT_SEL)
                | (mt_store[(k + 1) % STORE_DEPTH] & LOW_BITS_SEL);
            r = mt_store[(k + FAR_DISTANCE) % STORE_DEPTH] ^ (y >> 1);
            if (y[0]) begin
                r = r ^ TWIST_XOR;
            end
            mt_store[k] = r;
        end
        mt_index = 0;
    endfunction

    function automatic void seed_store(input logic [31:0] seed);
        logic [31:0] s;
        logic [31:0] upper;
        s = seed;
        for (int k = 0; k < STORE_DEPTH; k++) begin
            s = s * SEED_MUL + SEED_ADD;
            upper = s & 32'hffff_0000;
            s = s * SEED_MUL + SEED_ADD;
            mt_store[k] = upper | (s >> 16);
        end
        regenerate_store();
    endfunction

    function automatic logic [31:0] temper_word(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_MASK_B);
        y = y ^ ((y << 15) & TEMPER_MASK_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [31:0] next_word();
        logic [31:0] w;
        if (mt_index >= STORE_DEPTH) begin
            regenerate_store();
            wraps_seen++;
        end
        w = mt_store[mt_index];
        mt_index++;
        return temper_word(w);
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic go_idle(input int unsigned cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // offers one request, waits for it to be taken, then updates the model
    task automatic send_request(input logic op, input logic [31:0] seed);
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_seed_value <= seed;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (op == OP_DRAW) begin
            expected_words.push_back(next_word());
            draws_sent++;
        end else begin
            seed_store(seed);
            reseeds_sent++;
        end
    endtask

    // bursts of random length separated by random gaps
    task automatic sender_pace();
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0) begin
                go_idle(gap);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic paced_draw();
        send_request(OP_DRAW, $urandom);
        sender_pace();
    endtask

    task automatic wait_drained();
        go_idle(1);
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // result side: stall pattern, with an occasional long hold-off
    // ------------------------------------------------------------------
    initial begin : out_stall_pattern
        int unsigned mode;
        int unsigned run;
        run = 0;
        mode = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_done) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
                i_out_stall <= 1'b0;
            end else begin
                if (run == 0) begin
                    mode = $urandom_range(0, 3);
                    run = $urandom_range(10, 60);
                end
                run--;
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= 1'($urandom_range(0, 1));
                    2: i_out_stall <= ($urandom_range(0, 3) == 0);
                    default: i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $display("%0t unexpected random_word: expected none actual %08h",
                         $time, o_random_word);
                error_count++;
            end else begin
                if (expected_words[0] !== o_random_word) begin
                    $display("%0t mismatch random_word: expected %08h actual %08h",
                             $time, expected_words[0], o_random_word);
                    error_count++;
                end
                void'(expected_words.pop_front());
                words_checked++;
            end
        end
    end

    // a reseed keeps the core busy for less time than the watchdog limit
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: nothing moved for %0d cycles", $time, idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // extreme seeds, draws carrying extreme seed fields, back-to-back reseeds
    task automatic test_seed_extremes();
        send_request(OP_RESEED, 32'h0000_0000);
        sender_pace();
        send_request(OP_DRAW, 32'hffff_ffff);
        sender_pace();
        send_request(OP_DRAW, 32'h0000_0000);
        sender_pace();
        paced_draw();
        send_request(OP_RESEED, 32'hffff_ffff);
        sender_pace();
        repeat (3) paced_draw();
        send_request(OP_RESEED, 32'h8000_0000);
        sender_pace();
        repeat (2) paced_draw();
        send_request(OP_RESEED, 32'h0000_0001);
        send_request(OP_RESEED, 32'd5489);
        sender_pace();
        repeat (4) paced_draw();
    endtask

    // output held off while draws keep coming, then a full drain
    task automatic test_back_pressure();
        hold_requests <= hold_requests + 1;
        repeat (8) send_request(OP_DRAW, $urandom);
        wait_drained();
    endtask

    // enough draws after one reseed to run past the end of the store
    task automatic test_index_wrap();
        send_request(OP_RESEED, $urandom);
        sender_pace();
        repeat (STORE_DEPTH + 16) paced_draw();
    endtask

    task automatic test_random_sequences(input int unsigned n_items);
        int unsigned sent;
        int unsigned run;
        sent = 0;
        while (sent < n_items) begin
            send_request(OP_RESEED, $urandom);
            sender_pace();
            sent++;
            run = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 40);
            repeat (run) paced_draw();
            sent += run;
        end
    endtask

    initial begin
        error_count   = 0;
        reseeds_sent  = 0;
        draws_sent    = 0;
        words_checked = 0;
        wraps_seen    = 0;
        burst_left    = 0;
        holds_done    = 0;
        mt_index      = STORE_DEPTH;
        hold_requests <= 0;
        idle_cycles   <= 0;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_op          <= OP_RESEED;
        i_seed_value  <= 32'h0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_seed_extremes();
        test_back_pressure();
        test_index_wrap();
        test_random_sequences(330);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d reseeds, %0d draws, %0d words checked, %0d store wraps",
                 reseeds_sent, draws_sent, words_checked, wraps_seen);
        $display("with extreme seeds, a long output hold-off and random pacing");
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
